// ----- design/arfrc_pkg.sv -----
// Shared types and constants for the per-destination ARF rate controller.
// No dependencies; every other file of the block but arfrc_ram imports this package.
package arfrc_pkg;

   // Register file
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic [7:0] THRESHOLD_RESET = 8'd10;
   localparam logic [3:0] RETRIES_RESET   = 4'd7;
   // bit of paddr that picks between the two registers
   localparam int CSR_SEL_BIT  = 2;

   // Table size and number of rates, tied to the result field widths
   localparam int ADDRESS_ENTRIES = 16;
   localparam int RATE_LEVELS     = 8;

   // Fixed field widths
   localparam int ADDR_W    = 48;
   localparam int COUNT_W   = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [2:0] LOWEST_RATE = 3'd0;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] dest_addr;
      logic              acked;
      logic [2:0]        stages_used;
      logic              is_null;
   } req_type;

   typedef struct packed {
      logic [3:0] entry_index;
      logic       inserted;
      logic [2:0] primary_rate;
      logic [2:0] fallback_rate;
      logic [3:0] fallback_retries;
   } rsp_type;

   typedef enum logic {
      CMD_SELECT = 1'b0,
      CMD_REPORT = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      OP_SELECT,
      OP_REPORT,
      OP_NULL
   } op_kind_type;

   // Classified item held in the queue
   typedef struct packed {
      op_kind_type       kind;
      logic [ADDR_W-1:0] dest_addr;
      logic              first_ok;
      logic              acked;
   } op_type;

   // Queue head seen by the back end, with its valid flag
   typedef struct packed {
      logic   valid;
      op_type head;
   } queue_head_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_INSERT,
      BK_ROW
   } back_state_type;

endpackage

// ----- design/arfrc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arfrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/arfrc_front.sv -----
// Front end: takes items, classifies them and holds them in a short queue.
// Depends on arfrc_pkg.
module arfrc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  arfrc_pkg::req_type       req_item,
   output arfrc_pkg::queue_head_type q_head,
   input  logic                     q_pop
);
   import arfrc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   op_type            q_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              push;
   logic              full;
   op_type            op_new;

   // Classify the incoming item
   always_comb begin
      op_new.dest_addr = req_item.dest_addr;
      op_new.acked     = req_item.acked;
      op_new.first_ok  = (req_item.stages_used == 3'd1);
      if (req_item.command == CMD_SELECT) begin
         op_new.kind = OP_SELECT;
      end else if (req_item.is_null) begin
         op_new.kind = OP_NULL;
      end else begin
         op_new.kind = OP_REPORT;
      end
   end

   assign full = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign busy = full;
   assign push = start && !full;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_new;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.head  = q_ff[rd_ptr_ff];

endmodule

// ----- design/arfrc_back.sv -----
// Back end: address search and insert, per-entry rate and count update, result register.
// Depends on arfrc_pkg and arfrc_ram.
module arfrc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  arfrc_pkg::queue_head_type q_head,
   output logic                      q_pop,
   input  logic [7:0]                step_up_threshold,
   input  logic [3:0]                max_retries,
   output logic                      rsp_valid,
   output arfrc_pkg::rsp_type        rsp_item
);
   import arfrc_pkg::*;

   localparam int AW   = $clog2(ADDRESS_ENTRIES);
   localparam int RW   = $clog2(RATE_LEVELS);
   localparam int ROWW = RW + COUNT_W * RATE_LEVELS;
   localparam logic [AW-1:0] LAST_ENTRY = AW'(ADDRESS_ENTRIES - 1);
   localparam logic [RW-1:0] TOP_RATE   = RW'(RATE_LEVELS - 1);

   back_state_type       state_ff, state_in;
   op_type               op_ff, op_in;
   logic [AW-1:0]        k_ff, k_in;
   logic [AW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        cur_ff, cur_in;
   logic                 inserted_ff, inserted_in;
   logic [ADDRESS_ENTRIES-1:0] valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [AW-1:0]        tbl_raddr;
   logic                 tbl_we;
   logic [ADDR_W-1:0]    tbl_rdata;
   logic                 row_we;
   logic [ROWW-1:0]      row_rdata;
   logic [ROWW-1:0]      row_cur;
   logic [ROWW-1:0]      row_new;

   logic [AW:0]          k_next;
   logic                 search_last;

   logic [RW-1:0]        rate_old, rate1, rate_new;
   logic [COUNT_W-1:0]   cnt_old, cnt_new, cnt1;
   logic                 step;

   // Address table: written at the fill pointer, scanned one entry a cycle
   arfrc_ram #(.WIDTH(ADDR_W), .DEPTH(ADDRESS_ENTRIES)) u_tbl (
      .clock (clock),
      .we    (tbl_we),
      .waddr (fill_ff),
      .wdata (op_ff.dest_addr),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // Per-entry row: current rate and one success count per rate
   arfrc_ram #(.WIDTH(ROWW), .DEPTH(ADDRESS_ENTRIES)) u_row (
      .clock (clock),
      .we    (row_we),
      .waddr (cur_ff),
      .wdata (row_new),
      .raddr (cur_in),
      .rdata (row_rdata)
   );

   // A row never written reads as all zero
   assign row_cur  = valid_ff[cur_ff] ? row_rdata : '0;
   assign rate_old = row_cur[COUNT_W*RATE_LEVELS +: RW];

   // Report update of the current row
   always_comb begin
      cnt_old = '0;
      for (int i = 0; i < RATE_LEVELS; i++) begin
         if (rate_old == RW'(i)) begin
            cnt_old = row_cur[i*COUNT_W +: COUNT_W];
         end
      end
      if (op_ff.first_ok) begin
         cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
         rate1   = rate_old;
         cnt1    = cnt_new;
      end else begin
         cnt_new = (rate_old != '0) ? '0 : COUNT_W'(op_ff.acked);
         rate1   = '0;
         cnt1    = (rate_old != '0) ? row_cur[0 +: COUNT_W] : cnt_new;
      end
      step = (cnt1 >= step_up_threshold);
      if (step && rate1 != TOP_RATE) begin
         rate_new = rate1 + 1'b1;
      end else begin
         rate_new = rate1;
      end
      row_new = row_cur;
      for (int i = 0; i < RATE_LEVELS; i++) begin
         if (rate_old == RW'(i)) begin
            row_new[i*COUNT_W +: COUNT_W] = cnt_new;
         end
         if (step && rate1 == RW'(i)) begin
            row_new[i*COUNT_W +: COUNT_W] = '0;
         end
      end
      row_new[COUNT_W*RATE_LEVELS +: RW] = rate_new;
   end

   assign k_next      = {1'b0, k_ff} + 1'b1;
   assign search_last = (k_next == {1'b0, fill_ff});

   // Sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      fill_in      = fill_ff;
      cur_in       = cur_ff;
      inserted_in  = inserted_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      tbl_raddr    = '0;
      tbl_we       = 1'b0;
      row_we       = 1'b0;
      q_pop        = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_head.valid) begin
               q_pop       = 1'b1;
               op_in       = q_head.head;
               inserted_in = 1'b0;
               k_in        = '0;
               if (q_head.head.kind == OP_SELECT) begin
                  state_in = (fill_ff == '0) ? BK_INSERT : BK_SEARCH;
               end else begin
                  state_in = BK_ROW;
               end
            end
         end
         BK_SEARCH: begin
            if (tbl_rdata == op_ff.dest_addr) begin
               cur_in   = k_ff;
               state_in = BK_ROW;
            end else if (search_last) begin
               state_in = BK_INSERT;
            end else begin
               k_in      = AW'(k_next);
               tbl_raddr = AW'(k_next);
            end
         end
         BK_INSERT: begin
            tbl_we      = 1'b1;
            cur_in      = fill_ff;
            inserted_in = 1'b1;
            fill_in     = (fill_ff == LAST_ENTRY) ? '0 : fill_ff + 1'b1;
            state_in    = BK_ROW;
         end
         BK_ROW: begin
            row_we                  = (op_ff.kind == OP_REPORT);
            rsp_valid_in            = 1'b1;
            rsp_in.entry_index      = 4'(cur_ff);
            rsp_in.inserted         = inserted_ff;
            rsp_in.primary_rate     = (op_ff.kind == OP_REPORT) ? 3'(rate_new)
                                                                : 3'(rate_old);
            rsp_in.fallback_rate    = LOWEST_RATE;
            rsp_in.fallback_retries = max_retries;
            state_in                = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         cur_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         if (row_we) begin
            valid_ff[cur_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      k_ff        <= k_in;
      inserted_ff <= inserted_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- design/per_destination_arf_rate_control.sv -----
// Top level of the per-destination ARF rate controller: register file and wiring.
// Depends on arfrc_pkg, arfrc_front, arfrc_back and arfrc_ram.
//
// A select item scans the address table one entry a cycle through its single read port
// in the search state (skipped while the fill pointer is zero), then passes the insert
// state if the address is new, then the row state. A report goes straight to the row
// state for one read and one write of the current entry's row; a null report reads the
// row but does not write it. Items are held in a two-item queue in front of the
// sequencer, so busy rises only while two items wait. Each item gives exactly one
// result, shown for one cycle on rsp_valid and rsp_item; the receiver cannot hold it
// off. After reset the block takes items at once; no clearing pass is run.
module per_destination_arf_rate_control (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  arfrc_pkg::req_type                    req_item,
   output logic                                  rsp_valid,
   output arfrc_pkg::rsp_type                    rsp_item,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [arfrc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [arfrc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [arfrc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import arfrc_pkg::*;

   logic [7:0]     threshold_ff;
   logic [3:0]     retries_ff;
   logic           csr_wr;
   queue_head_type q_head;
   logic           q_pop;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         retries_ff   <= RETRIES_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[CSR_SEL_BIT]) begin
            retries_ff <= csr_pwdata[3:0];
         end else begin
            threshold_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign csr_prdata = csr_paddr[CSR_SEL_BIT] ? CSR_DATA_W'(retries_ff)
                                              : CSR_DATA_W'(threshold_ff);

   arfrc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   arfrc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .step_up_threshold (threshold_ff),
      .max_retries       (retries_ff),
      .rsp_valid         (rsp_valid),
      .rsp_item          (rsp_item)
   );

endmodule

// ----- design/arfrc_checker.sv -----
// Port-level checks for the per-destination ARF rate controller, bound to the top level.
// Depends on arfrc_pkg and per_destination_arf_rate_control.
module arfrc_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input arfrc_pkg::rsp_type rsp_item
);
   import arfrc_pkg::*;

   // Nothing pending and no result straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("result or busy seen right after reset");

   // The sequencer returns to idle after each row state, so strobes never abut
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result strobes in consecutive cycles");

   // Fallback is always the lowest rate
   a_fallback_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.fallback_rate == LOWEST_RATE))
      else $error("fallback rate is not the lowest rate");

   // Entry index stays inside the table
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_item.entry_index) < ADDRESS_ENTRIES))
      else $error("entry index beyond the address table");

endmodule

bind per_destination_arf_rate_control arfrc_checker u_arfrc_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
